FILE: src/assert_macros.svh
// assertion helpers; they expect clk and rst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define PRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define PRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/prb_pkg.sv
`default_nettype none

package prb_pkg;

  localparam int SIZE_W        = 13;
  localparam int LEN_W         = 13;
  localparam int OFF_W         = 12;
  localparam int DATA_W        = 8;
  localparam int SUM_W         = 14;
  localparam int MIN_SIZE      = 16;
  localparam int RESET_SIZE    = 4096;
  localparam int TRAILER_BYTES = 8;
  localparam int MOD_SHIFT     = SUM_W - $clog2(MIN_SIZE);
  localparam int MOD_CNT_W     = $clog2(MOD_SHIFT + 1);

  typedef enum logic [1:0] {
    REQ_WR_START = 2'd0,
    REQ_WR_DATA  = 2'd1,
    REQ_RD_START = 2'd2,
    REQ_RD_DATA  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_SEQ_ERR = 2'd2
  } status_t;

  typedef struct packed {
    req_t              req;
    logic [LEN_W-1:0]  length;
    logic              len_zero;
    logic [SUM_W-1:0]  need_room;
    logic [OFF_W-1:0]  read_offset;
    logic              advance;
    logic [DATA_W-1:0] data_in;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data_out;
    logic              last;
    logic [SIZE_W-1:0] bytes_to_read;
    logic [SIZE_W-1:0] bytes_to_write;
    logic              packet_ready;
  } result_t;

endpackage

`default_nettype wire

FILE: src/prb_ram.sv
`default_nettype none

module prb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/prb_mod.sv
`default_nettype none

module prb_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prb_pkg::SUM_W-1:0]  dividend,
  input  logic [prb_pkg::SIZE_W-1:0] divisor,
  output logic                       done,
  output logic [prb_pkg::SIZE_W-1:0] remainder
);

  import prb_pkg::*;

  localparam int DIV_W = SIZE_W + MOD_SHIFT;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]     acc_r;
  logic [DIV_W-1:0]     div_r;
  logic                 ge;

  assign ge = DIV_W'(acc_r) >= div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MOD_CNT_W'(MOD_SHIFT);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // shift-subtract: one multiple of the divisor tried per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      div_r <= DIV_W'(divisor) << MOD_SHIFT;
    end else if (busy_r) begin
      if (ge) begin
        acc_r <= SUM_W'(DIV_W'(acc_r) - div_r);
      end
      div_r <= div_r >> 1;
    end
  end

  assign done      = done_r;
  assign remainder = SIZE_W'(acc_r);

endmodule

`default_nettype wire

FILE: src/prb_front.sv
`default_nettype none

module prb_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [1:0]                 in_req_type,
  input  logic [prb_pkg::LEN_W-1:0]  in_length,
  input  logic [prb_pkg::OFF_W-1:0]  in_read_offset,
  input  logic                       in_advance,
  input  logic [prb_pkg::DATA_W-1:0] in_data_in,
  output logic                       full,
  input  logic                       pop,
  output logic                       empty,
  output prb_pkg::item_t             item
);

  import prb_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  item_t            q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  item_t            cls;
  logic             do_push;
  logic             do_pop;

  // decode and precompute what the back end checks
  always_comb begin
    cls.req         = req_t'(in_req_type);
    cls.length      = in_length;
    cls.len_zero    = (in_length == '0);
    cls.need_room   = SUM_W'(in_length) + SUM_W'(TRAILER_BYTES);
    cls.read_offset = in_read_offset;
    cls.advance     = in_advance;
    cls.data_in     = in_data_in;
  end

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign item    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: src/prb_back.sv
`default_nettype none

module prb_back #(
  parameter int RING_BYTES       = 4096,
  parameter int DESCRIPTOR_BYTES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [prb_pkg::SIZE_W-1:0] cfg_wdata,
  input  prb_pkg::item_t             item,
  input  logic                       item_empty,
  output logic                       item_pop,
  output logic                       out_valid,
  input  logic                       out_pop,
  output prb_pkg::result_t           result
);

  import prb_pkg::*;

  localparam int SIZE_MAX = (RING_BYTES < (2**SIZE_W) - 1) ? RING_BYTES : (2**SIZE_W) - 1;
  localparam int IW       = $clog2(SIZE_MAX);
  localparam int AW       = $clog2(RING_BYTES);
  localparam int TC_W     = $clog2(TRAILER_BYTES);
  localparam logic [SIZE_W-1:0] SIZE_RST =
    SIZE_W'((RESET_SIZE < SIZE_MAX) ? RESET_SIZE : SIZE_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_RDWAIT,
    S_TRAIL,
    S_STAT,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WRITE,
    MODE_READ
  } mode_t;

  state_t            state_r;
  mode_t             mode_r;
  item_t             item_r;
  logic [SIZE_W-1:0] size_r;
  logic [IW-1:0]     rd_idx_r;
  logic [IW-1:0]     wr_idx_r;
  logic [IW-1:0]     ptr_r;
  logic [IW-1:0]     old_r;
  logic [LEN_W-1:0]  rem_r;
  logic [TC_W-1:0]   tcnt_r;
  logic              consume_r;
  status_t           status_r;
  logic [DATA_W-1:0] dout_r;
  logic              last_r;
  logic [SIZE_W-1:0] free_r;
  logic [SIZE_W-1:0] free_nxt;
  logic              out_valid_r;
  result_t           result_r;

  logic [SIZE_W-1:0] readable;
  logic              room_fail;
  logic              data_fail;
  logic [IW-1:0]     ptr_inc;

  logic              ram_we;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              mod_start;
  logic              mod_done;
  logic [SIZE_W-1:0] mod_rem;
  logic [IW-1:0]     mod_ptr;

  function automatic logic [IW-1:0] inc_ptr(input logic [IW-1:0] p,
                                            input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] p1;
    p1 = SIZE_W'(p) + 1'b1;
    return (p1 == s) ? '0 : IW'(p1);
  endfunction

  // step past the trailer
  function automatic logic [IW-1:0] skip_trailer(input logic [IW-1:0] p,
                                                 input logic [SIZE_W-1:0] s);
    logic [SUM_W-1:0] p8;
    logic [SUM_W-1:0] s14;
    p8  = SUM_W'(p) + SUM_W'(TRAILER_BYTES);
    s14 = SUM_W'(s);
    return (p8 >= s14) ? IW'(p8 - s14) : IW'(p8);
  endfunction

  // trailer is the old write index shifted up by 32, little-endian
  function automatic logic [DATA_W-1:0] trailer_byte(input logic [IW-1:0] old,
                                                     input logic [TC_W-1:0] idx);
    logic [31:0] v;
    v = 32'(old) >> {idx[1:0], 3'b000};
    return idx[2] ? v[DATA_W-1:0] : '0;
  endfunction

  assign free_nxt  = (wr_idx_r >= rd_idx_r) ?
                     size_r - (SIZE_W'(wr_idx_r) - SIZE_W'(rd_idx_r)) :
                     SIZE_W'(rd_idx_r) - SIZE_W'(wr_idx_r);
  assign readable  = size_r - free_r;
  assign room_fail = (SUM_W'(free_r) <= item_r.need_room);
  assign data_fail = (readable < item_r.length);
  assign ptr_inc   = inc_ptr(ptr_r, size_r);
  assign mod_ptr   = IW'(mod_rem);

  assign item_pop  = (state_r == S_IDLE) && !item_empty;
  assign mod_start = (state_r == S_EXEC) && (item_r.req == REQ_RD_START) &&
                     (mode_r == MODE_IDLE) && !data_fail && item_r.advance;
  assign ram_we    = (state_r == S_TRAIL) ||
                     ((state_r == S_EXEC) && (item_r.req == REQ_WR_DATA) &&
                      (mode_r == MODE_WRITE));
  assign ram_wdata = (state_r == S_TRAIL) ? trailer_byte(old_r, tcnt_r) : item_r.data_in;

  prb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(ptr_r)),
    .wdata (ram_wdata),
    .raddr (AW'(ptr_r)),
    .rdata (ram_rdata)
  );

  prb_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (SUM_W'(rd_idx_r) + SUM_W'(item_r.read_offset)),
    .divisor   (size_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    free_r <= free_nxt;
    if (item_pop) begin
      item_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_IDLE;
      size_r      <= SIZE_RST;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      ptr_r       <= '0;
      rem_r       <= '0;
      tcnt_r      <= '0;
      consume_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (!item_empty) begin
            status_r <= ST_OK;
            dout_r   <= '0;
            last_r   <= 1'b0;
            state_r  <= S_EXEC;
          end
        end

        S_EXEC: begin
          state_r <= S_STAT;
          case (item_r.req)
            REQ_WR_START: begin
              if (mode_r != MODE_IDLE) begin
                status_r <= ST_SEQ_ERR;
              end else if (room_fail) begin
                status_r <= ST_NO_ROOM;
              end else if (item_r.len_zero) begin
                old_r   <= wr_idx_r;
                ptr_r   <= wr_idx_r;
                tcnt_r  <= '0;
                last_r  <= 1'b1;
                state_r <= S_TRAIL;
              end else begin
                mode_r <= MODE_WRITE;
                ptr_r  <= wr_idx_r;
                rem_r  <= item_r.length;
              end
            end
            REQ_WR_DATA: begin
              if (mode_r != MODE_WRITE) begin
                status_r <= ST_SEQ_ERR;
              end else begin
                ptr_r <= ptr_inc;
                rem_r <= rem_r - 1'b1;
                if (rem_r == LEN_W'(1)) begin
                  old_r   <= wr_idx_r;
                  tcnt_r  <= '0;
                  last_r  <= 1'b1;
                  state_r <= S_TRAIL;
                end
              end
            end
            REQ_RD_START: begin
              if (mode_r != MODE_IDLE) begin
                status_r <= ST_SEQ_ERR;
              end else if (data_fail) begin
                status_r <= ST_NO_ROOM;
              end else begin
                consume_r <= item_r.advance;
                if (item_r.advance) begin
                  state_r <= S_MOD;
                end else begin
                  ptr_r <= rd_idx_r;
                  if (item_r.len_zero) begin
                    last_r <= 1'b1;
                  end else begin
                    mode_r <= MODE_READ;
                    rem_r  <= item_r.length;
                  end
                end
              end
            end
            default: begin
              if (mode_r != MODE_READ) begin
                status_r <= ST_SEQ_ERR;
              end else begin
                state_r <= S_RDWAIT;
              end
            end
          endcase
        end

        S_MOD: begin
          if (mod_done) begin
            ptr_r   <= mod_ptr;
            state_r <= S_STAT;
            if (item_r.len_zero) begin
              last_r   <= 1'b1;
              rd_idx_r <= skip_trailer(mod_ptr, size_r);
            end else begin
              mode_r <= MODE_READ;
              rem_r  <= item_r.length;
            end
          end
        end

        S_RDWAIT: begin
          dout_r  <= ram_rdata;
          ptr_r   <= ptr_inc;
          rem_r   <= rem_r - 1'b1;
          state_r <= S_STAT;
          if (rem_r == LEN_W'(1)) begin
            last_r <= 1'b1;
            mode_r <= MODE_IDLE;
            if (consume_r) begin
              rd_idx_r <= skip_trailer(ptr_inc, size_r);
            end
          end
        end

        S_TRAIL: begin
          ptr_r  <= ptr_inc;
          tcnt_r <= tcnt_r + 1'b1;
          if (tcnt_r == TC_W'(TRAILER_BYTES - 1)) begin
            wr_idx_r <= ptr_inc;
            mode_r   <= MODE_IDLE;
            state_r  <= S_STAT;
          end
        end

        // free space settles from the final indices
        S_STAT: begin
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r             <= 1'b1;
            result_r.status         <= status_r;
            result_r.data_out       <= dout_r;
            result_r.last           <= last_r;
            result_r.bytes_to_read  <= readable;
            result_r.bytes_to_write <= free_r;
            result_r.packet_ready   <= (readable >= SIZE_W'(DESCRIPTOR_BYTES));
            state_r                 <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // size change empties the ring and drops any transfer
      if (cfg_we) begin
        if (cfg_wdata < SIZE_W'(MIN_SIZE)) begin
          size_r <= SIZE_W'(MIN_SIZE);
        end else if (cfg_wdata > SIZE_W'(SIZE_MAX)) begin
          size_r <= SIZE_W'(SIZE_MAX);
        end else begin
          size_r <= cfg_wdata;
        end
        rd_idx_r  <= '0;
        wr_idx_r  <= '0;
        ptr_r     <= '0;
        rem_r     <= '0;
        mode_r    <= MODE_IDLE;
        consume_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

FILE: src/packet_ring_buffer_engine.sv
// Byte ring with framed packets, seen as a queue on both sides: push/full
// for request items, empty/pop for the one status item each request returns.
// Requests are decoded into a two-entry queue and then carried out one at a
// time by a sequencer that owns the ring memory (one write or read port
// access per cycle). From the head of the queue, a plain item passes the
// execute, status and emit states to the result register; read_data adds a
// read-wait state for the registered memory read; a packet-ending write_data
// or zero-length write_start adds a trailer state where the sequencer lays
// down the 8 trailer bytes; an advancing read_start waits in a modulo state
// for the bit-at-a-time unit that wraps read index plus offset. Writing
// cfg_wdata empties the ring. No initialization pass is needed after reset.
`default_nettype none
`include "assert_macros.svh"

module packet_ring_buffer_engine #(
  parameter int RING_BYTES       = 4096,
  parameter int DESCRIPTOR_BYTES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [prb_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_req_type,
  input  logic [prb_pkg::LEN_W-1:0]  in_length,
  input  logic [prb_pkg::OFF_W-1:0]  in_read_offset,
  input  logic                       in_advance,
  input  logic [prb_pkg::DATA_W-1:0] in_data_in,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 out_status,
  output logic [prb_pkg::DATA_W-1:0] out_data_out,
  output logic                       out_last,
  output logic [prb_pkg::SIZE_W-1:0] out_bytes_to_read,
  output logic [prb_pkg::SIZE_W-1:0] out_bytes_to_write,
  output logic                       out_packet_ready
);

  import prb_pkg::*;

  item_t   item;
  logic    item_empty;
  logic    item_pop;
  logic    out_valid;
  result_t result;

  prb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_req_type    (in_req_type),
    .in_length      (in_length),
    .in_read_offset (in_read_offset),
    .in_advance     (in_advance),
    .in_data_in     (in_data_in),
    .full           (full),
    .pop            (item_pop),
    .empty          (item_empty),
    .item           (item)
  );

  prb_back #(
    .RING_BYTES       (RING_BYTES),
    .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .result     (result)
  );

  assign empty              = !out_valid;
  assign out_status         = result.status;
  assign out_data_out       = result.data_out;
  assign out_last           = result.last;
  assign out_bytes_to_read  = result.bytes_to_read;
  assign out_bytes_to_write = result.bytes_to_write;
  assign out_packet_ready   = result.packet_ready;

  // a completed transfer is never reported together with an error
  `PRB_ASSERT_NOW(a_last_ok, !empty && out_last, out_status == ST_OK, "last item with error status")
  // bytes come back only from an accepted read
  `PRB_ASSERT_NOW(a_data_ok, !empty && out_data_out != '0, out_status == ST_OK, "data on rejected item")
  // write index never catches up with the read index
  `PRB_ASSERT_NOW(a_free_nonzero, !empty, out_bytes_to_write != '0, "ring reports no free byte")

endmodule

`default_nettype wire
